[src/wdm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wdm_pkg
// Types and constants shared by the weight drop monitor: command codes,
// register indexes, the configuration set and the control state.
// ----------------------------------------------------------------------------
package wdm_pkg;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_CLEAR   = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    localparam int REG_INDEX_BITS = 3;
    localparam int PADDR_BITS     = 5;
    localparam int PDATA_BITS     = 32;

    localparam logic [REG_INDEX_BITS-1:0] REG_SAMPLE_INTERVAL = 3'd0;
    localparam logic [REG_INDEX_BITS-1:0] REG_ERROR_THRESHOLD = 3'd1;
    localparam logic [REG_INDEX_BITS-1:0] REG_DIFF_THRESHOLD  = 3'd2;
    localparam logic [REG_INDEX_BITS-1:0] REG_ALERT_ON        = 3'd3;
    localparam logic [REG_INDEX_BITS-1:0] REG_SKIP_INTERVAL   = 3'd4;
    localparam logic [REG_INDEX_BITS-1:0] REG_SKIP_TIME       = 3'd5;

    localparam logic [15:0] SECONDS_PER_MINUTE = 16'd60;
    localparam logic [7:0]  COUNT_MAX          = 8'hFF;

    typedef struct packed {
        logic [7:0]  sample_interval;
        logic [7:0]  error_threshold;
        logic [15:0] diff_threshold_milli;
        logic        alert_on;
        logic [9:0]  check_minutes;
        logic [9:0]  skip_minutes;
    } t_cfg;

    typedef struct packed {
        logic        baseline_valid;
        logic [7:0]  sample_tick_count;
        logic [7:0]  low_diff_count;
        logic        alarm_latched;
        logic        skip_active;
        logic [15:0] check_seconds;
        logic [15:0] skip_seconds;
    } t_ctl;

endpackage
`default_nettype wire

[src/wdm_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wdm_step
// Next-state logic for one item: skip duty timer, sample counter, weight
// difference, error counting and alarm latch.
// ----------------------------------------------------------------------------
module wdm_step import wdm_pkg::*; #(
    parameter int WEIGHT_BITS = 24
) (
    input  var t_cfg                     i_cfg,
    input  var t_ctl                     i_ctl,
    input  var t_cmd                     i_cmd,
    input  wire logic [WEIGHT_BITS-1:0]  i_weight,
    input  wire logic [WEIGHT_BITS-1:0]  i_prev_weight,
    input  wire logic [WEIGHT_BITS:0]    i_last_diff,
    output t_ctl                         o_ctl,
    output logic [WEIGHT_BITS-1:0]       o_prev_weight,
    output logic [WEIGHT_BITS:0]         o_last_diff,
    output logic                         o_sampled
);

    logic [15:0]            check_inc;
    logic [15:0]            skip_inc;
    logic [15:0]            check_limit;
    logic [15:0]            skip_limit;
    logic [7:0]             tick_inc;
    logic [WEIGHT_BITS-1:0] base_weight;
    logic signed [WEIGHT_BITS:0] diff;
    logic signed [WEIGHT_BITS:0] diff_threshold;
    t_ctl                   ctl;

    assign check_inc   = i_ctl.check_seconds + 16'd1;
    assign skip_inc    = i_ctl.skip_seconds + 16'd1;
    assign check_limit = 16'({6'd0, i_cfg.check_minutes} * SECONDS_PER_MINUTE);
    assign skip_limit  = 16'({6'd0, i_cfg.skip_minutes} * SECONDS_PER_MINUTE);
    assign tick_inc    = i_ctl.sample_tick_count + 8'd1;
    assign base_weight = i_ctl.baseline_valid ? i_prev_weight : i_weight;
    assign diff = $signed({i_weight[WEIGHT_BITS-1], i_weight})
                - $signed({base_weight[WEIGHT_BITS-1], base_weight});
    assign diff_threshold = $signed({{(WEIGHT_BITS-15){i_cfg.diff_threshold_milli[15]}},
                                     i_cfg.diff_threshold_milli});

    always_comb begin
        ctl           = i_ctl;
        o_prev_weight = i_prev_weight;
        o_last_diff   = i_last_diff;
        o_sampled     = 1'b0;
        case (i_cmd)
            CMD_TICK: begin
                if (i_cfg.check_minutes != 10'd0 && !i_ctl.alarm_latched) begin
                    if (i_ctl.skip_active) begin
                        if (skip_inc >= skip_limit) begin
                            ctl.skip_seconds = 16'd0;
                            ctl.skip_active  = 1'b0;
                        end else begin
                            ctl.skip_seconds = skip_inc;
                        end
                    end else begin
                        if (check_inc >= check_limit) begin
                            ctl.check_seconds = 16'd0;
                            ctl.skip_active   = 1'b1;
                        end else begin
                            ctl.check_seconds = check_inc;
                        end
                    end
                end
                if (!ctl.skip_active) begin
                    ctl.sample_tick_count = tick_inc;
                    if (tick_inc >= i_cfg.sample_interval) begin
                        ctl.sample_tick_count = 8'd0;
                        ctl.baseline_valid    = 1'b1;
                        o_sampled             = 1'b1;
                        o_last_diff           = diff;
                        o_prev_weight         = i_weight;
                        if (i_cfg.alert_on) begin
                            if (diff < diff_threshold) begin
                                if (i_ctl.low_diff_count != COUNT_MAX) begin
                                    ctl.low_diff_count = i_ctl.low_diff_count + 8'd1;
                                end
                            end else begin
                                ctl.low_diff_count = 8'd0;
                            end
                        end
                    end
                    if (!ctl.alarm_latched && ctl.low_diff_count >= i_cfg.error_threshold) begin
                        ctl.alarm_latched = 1'b1;
                    end
                end
            end
            CMD_CLEAR: begin
                if (i_ctl.alarm_latched) begin
                    ctl.low_diff_count = 8'd0;
                    ctl.alarm_latched  = 1'b0;
                    ctl.baseline_valid = 1'b0;
                end
                if (!ctl.skip_active && !ctl.alarm_latched
                        && ctl.low_diff_count >= i_cfg.error_threshold) begin
                    ctl.alarm_latched = 1'b1;
                end
            end
            CMD_RESTART: begin
                ctl.low_diff_count    = 8'd0;
                ctl.alarm_latched     = 1'b0;
                ctl.baseline_valid    = 1'b0;
                ctl.skip_active       = 1'b0;
                ctl.check_seconds     = 16'd0;
                ctl.skip_seconds      = 16'd0;
                ctl.sample_tick_count = 8'd0;
            end
            default: begin
                ctl = i_ctl;
            end
        endcase
        o_ctl = ctl;
    end

endmodule
`default_nettype wire

[src/weight_drop_monitor_with_skip_timer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// weight_drop_monitor_with_skip_timer
// Load-cell weight drop monitor with a skip duty timer and a latching alarm.
// ----------------------------------------------------------------------------
// Each item is a command (tick, clear, restart) with a weight. An item is
// registered at the input, processed by one pass of next-state logic, and
// its result is held in an output register, so the block takes one item per
// cycle unless the result side stalls, which holds the output register and
// then the input register. The user must write configuration through the
// APB port while no item is in flight; the block does not enforce this.
module weight_drop_monitor_with_skip_timer import wdm_pkg::*; #(
    parameter int WEIGHT_BITS = 24
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [PADDR_BITS-1:0]   paddr,
    input  wire logic [PDATA_BITS-1:0]   pwdata,
    output logic [PDATA_BITS-1:0]        prdata,
    output logic                         pready,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [1:0]              i_cmd,
    input  wire logic [WEIGHT_BITS-1:0]  i_weight_milli,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic                         o_alarm,
    output logic                         o_skipping,
    output logic                         o_sampled,
    output logic [WEIGHT_BITS:0]         o_weight_diff_milli,
    output logic [7:0]                   o_error_count
);

    t_cfg                   r_cfg;
    t_ctl                   r_ctl;
    t_ctl                   n_ctl;
    logic [WEIGHT_BITS-1:0] r_prev_weight;
    logic [WEIGHT_BITS-1:0] n_prev_weight;
    logic [WEIGHT_BITS:0]   r_last_diff;
    logic [WEIGHT_BITS:0]   n_last_diff;
    logic                   n_sampled;

    logic                   r_in_valid;
    t_cmd                   r_in_cmd;
    logic [WEIGHT_BITS-1:0] r_in_weight;

    logic                   r_out_valid;
    logic                   r_out_sampled;

    logic                   out_free;
    logic                   proc_move;
    logic                   in_take;
    logic                   cfg_write;
    logic [REG_INDEX_BITS-1:0] reg_index;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc_move  = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;
    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite;
    assign reg_index  = paddr[PADDR_BITS-1:2];

    wdm_step #(
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_step (
        .i_cfg         (r_cfg),
        .i_ctl         (r_ctl),
        .i_cmd         (r_in_cmd),
        .i_weight      (r_in_weight),
        .i_prev_weight (r_prev_weight),
        .i_last_diff   (r_last_diff),
        .o_ctl         (n_ctl),
        .o_prev_weight (n_prev_weight),
        .o_last_diff   (n_last_diff),
        .o_sampled     (n_sampled)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_interval      <= 8'd5;
            r_cfg.error_threshold      <= 8'd3;
            r_cfg.diff_threshold_milli <= 16'd0;
            r_cfg.alert_on             <= 1'b1;
            r_cfg.check_minutes        <= 10'd0;
            r_cfg.skip_minutes         <= 10'd0;
        end else if (cfg_write) begin
            case (reg_index)
                REG_SAMPLE_INTERVAL: r_cfg.sample_interval      <= pwdata[7:0];
                REG_ERROR_THRESHOLD: r_cfg.error_threshold      <= pwdata[7:0];
                REG_DIFF_THRESHOLD:  r_cfg.diff_threshold_milli <= pwdata[15:0];
                REG_ALERT_ON:        r_cfg.alert_on             <= pwdata[0];
                REG_SKIP_INTERVAL:   r_cfg.check_minutes        <= pwdata[9:0];
                REG_SKIP_TIME:       r_cfg.skip_minutes         <= pwdata[9:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_SAMPLE_INTERVAL: prdata = {24'd0, r_cfg.sample_interval};
            REG_ERROR_THRESHOLD: prdata = {24'd0, r_cfg.error_threshold};
            REG_DIFF_THRESHOLD:  prdata = {16'd0, r_cfg.diff_threshold_milli};
            REG_ALERT_ON:        prdata = {31'd0, r_cfg.alert_on};
            REG_SKIP_INTERVAL:   prdata = {22'd0, r_cfg.check_minutes};
            REG_SKIP_TIME:       prdata = {22'd0, r_cfg.skip_minutes};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_ctl         <= '0;
            r_prev_weight <= '0;
            r_last_diff   <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (proc_move) begin
                r_in_valid <= 1'b0;
            end
            if (proc_move) begin
                r_out_valid   <= 1'b1;
                r_ctl         <= n_ctl;
                r_prev_weight <= n_prev_weight;
                r_last_diff   <= n_last_diff;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_cmd    <= t_cmd'(i_cmd);
            r_in_weight <= i_weight_milli;
        end
        if (proc_move) begin
            r_out_sampled <= n_sampled;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_alarm             = r_ctl.alarm_latched;
    assign o_skipping          = r_ctl.skip_active;
    assign o_sampled           = r_out_sampled;
    assign o_weight_diff_milli = r_last_diff;
    assign o_error_count       = r_ctl.low_diff_count;

endmodule
`default_nettype wire
